### rtl/tarq_pkg.sv
// ----------------------------------------------------------------------------
// tarq_pkg: shared types and constants of the tetrahedron quality pipeline
// Field widths, internal word widths and the stage-to-stage payload structs.
// ----------------------------------------------------------------------------
package tarq_pkg;

  // Interface widths
  localparam int CoordW   = 16;
  localparam int FracBits = 16;
  localparam int QualW    = FracBits + 2;

  // Geometry words
  localparam int DiffW  = CoordW + 1;       // vertex difference
  localparam int SqW    = 2 * CoordW;       // squared difference, unsigned
  localparam int Sum6W  = SqW + 3;          // sum of six squares
  localparam int SumW   = SqW + 5;          // sum of eighteen squares (S)
  localparam int CrossW = 2 * DiffW;        // cross product component
  localparam int DotW   = DiffW + CrossW;   // one dot product term
  localparam int DetW   = DotW + 2;         // six times signed volume (D)
  localparam int MagW   = DetW - 1;         // |D|

  // Power words
  localparam int SLoW    = (SumW + 1) / 2;
  localparam int SHiW    = SumW - SLoW;
  localparam int S2W     = 2 * SumW;
  localparam int DLoW    = (MagW + 1) / 2;
  localparam int DHiW    = MagW - DLoW;
  localparam int D2W     = 2 * MagW;
  localparam int S2LimbW = (S2W + 2) / 3;
  localparam int S2PadW  = 3 * S2LimbW;
  localparam int S3W     = 3 * SumW;

  // 432 = (12*sqrt(3))^2, scale of D^2 against S^3
  localparam int K2  = 432;
  localparam int K2W = 9;

  // Quotient / root words
  localparam int TW       = 2 * FracBits;     // D^2 scaled / S^3, overflow flagged by sat
  localparam int RW       = D2W + K2W + TW;   // dividend
  localparam int RootRemW = FracBits + 3;

  typedef struct packed {
    logic signed [CoordW-1:0] a_x;
    logic signed [CoordW-1:0] a_y;
    logic signed [CoordW-1:0] a_z;
    logic signed [CoordW-1:0] b_x;
    logic signed [CoordW-1:0] b_y;
    logic signed [CoordW-1:0] b_z;
    logic signed [CoordW-1:0] c_x;
    logic signed [CoordW-1:0] c_y;
    logic signed [CoordW-1:0] c_z;
    logic signed [CoordW-1:0] d_x;
    logic signed [CoordW-1:0] d_y;
    logic signed [CoordW-1:0] d_z;
  } tarq_in_t;

  typedef struct packed {
    logic signed [QualW-1:0] quality;
    logic                    degenerate;
  } tarq_out_t;

  typedef struct packed {
    logic        [SumW-1:0] s;
    logic signed [DetW-1:0] d;
  } tarq_geom_t;

  typedef struct packed {
    logic [S3W-1:0] s3;
    logic [RW-1:0]  r;
    logic           neg;
    logic           deg;
  } tarq_pow_t;

  typedef struct packed {
    logic neg;
    logic deg;
    logic sat;
  } tarq_meta_t;

  typedef struct packed {
    logic [TW-1:0] t;
    tarq_meta_t    meta;
  } tarq_quot_t;

  typedef struct packed {
    logic [FracBits-1:0] q;
    tarq_meta_t          meta;
  } tarq_root_t;

endpackage

### rtl/tetra_aspect_ratio_quality.sv
// ----------------------------------------------------------------------------
// tetra_aspect_ratio_quality: streaming tetrahedron aspect-ratio quality
// Takes four vertices per transaction and returns the signed Q1.16 quality
// (1.0 for a regular tetrahedron, negative when inverted) and a degenerate
// flag when all vertices coincide.
//
// Channels: in_valid_i/in_ready_o/in_data_i carries one tetrahedron,
// out_valid_o/out_ready_i/out_data_o one result per tetrahedron, in order.
// Throughput: one transaction per cycle while the skid is empty.
// Pipeline: 4 geometry stages, 4 power stages, 33 divider stages, 16 square
// root stages and the output register between input acceptance and out_valid_o.
// The divider and square root produce one bit per stage, which sets the
// depth. Stall: a two-entry output (register plus skid) keeps accepting while
// the receiver stalls; once the skid holds a transaction, in_ready_o drops and
// the whole pipeline freezes until the skid drains.
// Reset: clears all valid bits, including output/skid valid; no configuration.
// ----------------------------------------------------------------------------
module tetra_aspect_ratio_quality (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tarq_pkg::tarq_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tarq_pkg::tarq_out_t out_data_o
);
  import tarq_pkg::*;

  logic       en;
  logic       geom_valid, pow_valid, div_valid, root_valid;
  tarq_geom_t geom_data;
  tarq_pow_t  pow_data;
  tarq_quot_t div_data;
  tarq_root_t root_data;

  logic [FracBits:0] q_mag;
  tarq_out_t         fin;

  logic      out_valid_q, skid_valid_q;
  tarq_out_t out_q, skid_q;

  // pipeline advances whenever the skid is free
  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  tarq_geom u_geom (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_valid_i), .data_i(in_data_i),
    .valid_o(geom_valid), .data_o(geom_data)
  );

  tarq_power u_power (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(geom_valid), .data_i(geom_data),
    .valid_o(pow_valid), .data_o(pow_data)
  );

  tarq_div u_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(pow_valid), .data_i(pow_data),
    .valid_o(div_valid), .data_o(div_data)
  );

  tarq_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(div_valid), .data_i(div_data),
    .valid_o(root_valid), .data_o(root_data)
  );

  // Saturated ratio means root >= 1.0: clamp to exactly one.
  assign q_mag = root_data.meta.sat ? {1'b1, {FracBits{1'b0}}} : {1'b0, root_data.q};

  always_comb begin
    fin.degenerate = root_data.meta.deg;
    if (root_data.meta.deg) begin
      fin.quality = '0;
    end else if (root_data.meta.neg) begin
      fin.quality = -QualW'(q_mag);
    end else begin
      fin.quality = QualW'(q_mag);
    end
  end

  // Output register with skid: the final stage is consumed exactly when en.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && !out_ready_i) begin
      if (!skid_valid_q && root_valid) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= root_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && !out_ready_i) begin
      if (!skid_valid_q) begin
        skid_q <= fin;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else begin
      out_q <= fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/tarq_geom.sv
// ----------------------------------------------------------------------------
// tarq_geom: edge lengths and signed volume
// Four stages: differences, squares and cross product, partial sums and dot
// terms, final sum S and determinant D.
// ----------------------------------------------------------------------------
module tarq_geom (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  tarq_pkg::tarq_in_t  data_i,
  output logic                valid_o,
  output tarq_pkg::tarq_geom_t data_o
);
  import tarq_pkg::*;

  localparam int NumEdges = 6;
  localparam int NumAxes  = 3;
  localparam int NumStg   = 4;
  localparam int unsigned EdgeA [NumEdges] = '{0, 0, 0, 1, 1, 2};
  localparam int unsigned EdgeB [NumEdges] = '{1, 2, 3, 2, 3, 3};

  logic signed [CoordW-1:0]  vtx [4][NumAxes];
  logic signed [DiffW-1:0]   edge_d [NumEdges][NumAxes];
  logic signed [DiffW-1:0]   edge_q [NumEdges][NumAxes];
  logic signed [2*DiffW-1:0] sq_full [NumEdges][NumAxes];
  logic        [SqW-1:0]     sq_q [NumEdges][NumAxes];
  logic signed [CrossW-1:0]  cp_a [NumAxes];
  logic signed [CrossW-1:0]  cp_b [NumAxes];
  logic signed [CrossW-1:0]  cross_q [NumAxes];
  logic signed [DiffW-1:0]   dvec_q [NumAxes];
  logic        [Sum6W-1:0]   psum_d [3];
  logic        [Sum6W-1:0]   psum_q [3];
  logic signed [DotW-1:0]    dot_d [NumAxes];
  logic signed [DotW-1:0]    dot_q [NumAxes];
  logic        [SumW-1:0]    s_q;
  logic signed [DetW-1:0]    d_q;
  logic        [NumStg-1:0]  v_q;

  always_comb begin
    vtx[0][0] = data_i.a_x; vtx[0][1] = data_i.a_y; vtx[0][2] = data_i.a_z;
    vtx[1][0] = data_i.b_x; vtx[1][1] = data_i.b_y; vtx[1][2] = data_i.b_z;
    vtx[2][0] = data_i.c_x; vtx[2][1] = data_i.c_y; vtx[2][2] = data_i.c_z;
    vtx[3][0] = data_i.d_x; vtx[3][1] = data_i.d_y; vtx[3][2] = data_i.d_z;
    for (int j = 0; j < NumEdges; j++) begin
      for (int k = 0; k < NumAxes; k++) begin
        edge_d[j][k] = DiffW'(vtx[EdgeB[j]][k]) - DiffW'(vtx[EdgeA[j]][k]);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < NumEdges; j++) begin
      for (int k = 0; k < NumAxes; k++) begin
        sq_full[j][k] = edge_q[j][k] * edge_q[j][k];
      end
    end
    // (b-a) x (c-a)
    cp_a[0] = edge_q[0][1] * edge_q[1][2];
    cp_b[0] = edge_q[0][2] * edge_q[1][1];
    cp_a[1] = edge_q[0][2] * edge_q[1][0];
    cp_b[1] = edge_q[0][0] * edge_q[1][2];
    cp_a[2] = edge_q[0][0] * edge_q[1][1];
    cp_b[2] = edge_q[0][1] * edge_q[1][0];
  end

  always_comb begin
    for (int g = 0; g < 3; g++) begin
      psum_d[g] = '0;
      for (int j = 2 * g; j < 2 * g + 2; j++) begin
        for (int k = 0; k < NumAxes; k++) begin
          psum_d[g] = psum_d[g] + Sum6W'(sq_q[j][k]);
        end
      end
    end
    for (int k = 0; k < NumAxes; k++) begin
      dot_d[k] = dvec_q[k] * cross_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      edge_q <= edge_d;
      for (int j = 0; j < NumEdges; j++) begin
        for (int k = 0; k < NumAxes; k++) begin
          sq_q[j][k] <= sq_full[j][k][SqW-1:0];
        end
      end
      for (int k = 0; k < NumAxes; k++) begin
        cross_q[k] <= cp_a[k] - cp_b[k];
        dvec_q[k]  <= edge_q[2][k];
      end
      psum_q <= psum_d;
      dot_q  <= dot_d;
      s_q    <= SumW'(psum_q[0]) + SumW'(psum_q[1]) + SumW'(psum_q[2]);
      d_q    <= DetW'(dot_q[0]) + DetW'(dot_q[1]) + DetW'(dot_q[2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NumStg-2:0], valid_i};
    end
  end

  assign valid_o  = v_q[NumStg-1];
  assign data_o.s = s_q;
  assign data_o.d = d_q;

endmodule

### rtl/tarq_power.sv
// ----------------------------------------------------------------------------
// tarq_power: S^3 and scaled D^2
// Four stages of limb products and sums; output is divisor S^3 and the
// dividend 432 * D^2 * 2^(2*FracBits).
// ----------------------------------------------------------------------------
module tarq_power (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  tarq_pkg::tarq_geom_t data_i,
  output logic                 valid_o,
  output tarq_pkg::tarq_pow_t  data_o
);
  import tarq_pkg::*;

  localparam int NumStg = 4;

  // stage A: |D|, S limb products
  logic [MagW-1:0]        a_mag_q;
  logic                   a_neg_q, a_deg_q;
  logic [SumW-1:0]        a_s_q;
  logic [2*SHiW-1:0]      a_shh_q;
  logic [SHiW+SLoW-1:0]   a_shl_q;
  logic [2*SLoW-1:0]      a_sll_q;
  logic [SHiW-1:0]        s_hi;
  logic [SLoW-1:0]        s_lo;
  logic [2*SHiW-1:0]      shh;
  logic [SHiW+SLoW-1:0]   shl;
  logic [2*SLoW-1:0]      sll;
  logic signed [DetW-1:0] d_neg;

  // stage B: S^2, D limb products
  logic [S2W-1:0]         b_s2_q;
  logic [SumW-1:0]        b_s_q;
  logic                   b_neg_q, b_deg_q;
  logic [2*DHiW-1:0]      b_dhh_q;
  logic [DHiW+DLoW-1:0]   b_dhl_q;
  logic [2*DLoW-1:0]      b_dll_q;
  logic [DHiW-1:0]        d_hi;
  logic [DLoW-1:0]        d_lo;
  logic [2*DHiW-1:0]      dhh;
  logic [DHiW+DLoW-1:0]   dhl;
  logic [2*DLoW-1:0]      dll;

  // stage C: D^2, S^3 limb products
  logic [D2W-1:0]         c_d2_q;
  logic                   c_neg_q, c_deg_q;
  logic [S2PadW-1:0]      s2_pad;
  logic [S2LimbW+SumW-1:0] s3_pp [3];
  logic [S2LimbW+SumW-1:0] c_pp_q [3];

  // stage D
  logic [D2W+K2W-1:0]     dk;
  logic [S3W-1:0]         d_s3_q;
  logic [RW-1:0]          d_r_q;
  logic                   d_neg_q, d_deg_q;
  logic [NumStg-1:0]      v_q;

  assign s_hi  = data_i.s[SumW-1 -: SHiW];
  assign s_lo  = data_i.s[SLoW-1:0];
  assign shh   = s_hi * s_hi;
  assign shl   = s_hi * s_lo;
  assign sll   = s_lo * s_lo;
  assign d_neg = -data_i.d;

  assign d_hi = a_mag_q[MagW-1 -: DHiW];
  assign d_lo = a_mag_q[DLoW-1:0];
  assign dhh  = d_hi * d_hi;
  assign dhl  = d_hi * d_lo;
  assign dll  = d_lo * d_lo;

  assign s2_pad = S2PadW'(b_s2_q);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_pp[i] = s2_pad[i*S2LimbW +: S2LimbW] * b_s_q;
    end
  end

  assign dk = c_d2_q * K2W'(K2);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_neg_q <= data_i.d[DetW-1];
      a_mag_q <= data_i.d[DetW-1] ? d_neg[MagW-1:0] : data_i.d[MagW-1:0];
      a_deg_q <= (data_i.s == '0);
      a_s_q   <= data_i.s;
      a_shh_q <= shh;
      a_shl_q <= shl;
      a_sll_q <= sll;

      b_s2_q  <= (S2W'(a_shh_q) << (2 * SLoW)) + (S2W'(a_shl_q) << (SLoW + 1))
               + S2W'(a_sll_q);
      b_s_q   <= a_s_q;
      b_neg_q <= a_neg_q;
      b_deg_q <= a_deg_q;
      b_dhh_q <= dhh;
      b_dhl_q <= dhl;
      b_dll_q <= dll;

      c_d2_q  <= (D2W'(b_dhh_q) << (2 * DLoW)) + (D2W'(b_dhl_q) << (DLoW + 1))
               + D2W'(b_dll_q);
      c_pp_q  <= s3_pp;
      c_neg_q <= b_neg_q;
      c_deg_q <= b_deg_q;

      d_s3_q  <= S3W'(c_pp_q[0]) + (S3W'(c_pp_q[1]) << S2LimbW)
               + (S3W'(c_pp_q[2]) << (2 * S2LimbW));
      d_r_q   <= {dk, {TW{1'b0}}};
      d_neg_q <= c_neg_q;
      d_deg_q <= c_deg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NumStg-2:0], valid_i};
    end
  end

  assign valid_o     = v_q[NumStg-1];
  assign data_o.s3   = d_s3_q;
  assign data_o.r    = d_r_q;
  assign data_o.neg  = d_neg_q;
  assign data_o.deg  = d_deg_q;

endmodule

### rtl/tarq_div.sv
// ----------------------------------------------------------------------------
// tarq_div: pipelined restoring divider
// First stage checks quotient overflow (>= 2^TW), then one quotient bit per
// stage, largest first.
// ----------------------------------------------------------------------------
module tarq_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  tarq_pkg::tarq_pow_t  data_i,
  output logic                 valid_o,
  output tarq_pkg::tarq_quot_t data_o
);
  import tarq_pkg::*;

  localparam int NumStg = TW + 1;

  logic [RW-1:0]     src_rem [NumStg];
  logic [S3W-1:0]    src_s3  [NumStg];
  logic [TW-1:0]     src_t   [NumStg];
  logic [RW-1:0]     trial   [NumStg];
  logic              ge      [NumStg];
  logic [RW-1:0]     rem_q   [NumStg];
  logic [S3W-1:0]    s3_q    [NumStg];
  logic [TW-1:0]     t_q     [NumStg];
  tarq_meta_t        meta_d  [NumStg];
  tarq_meta_t        meta_q  [NumStg];
  logic [NumStg-1:0] v_q;

  always_comb begin
    for (int i = 0; i < NumStg; i++) begin
      if (i == 0) begin
        src_rem[i]    = data_i.r;
        src_s3[i]     = data_i.s3;
        src_t[i]      = '0;
        meta_d[i].neg = data_i.neg;
        meta_d[i].deg = data_i.deg;
      end else begin
        src_rem[i]    = rem_q[i-1];
        src_s3[i]     = s3_q[i-1];
        src_t[i]      = t_q[i-1];
        meta_d[i]     = meta_q[i-1];
      end
      trial[i] = RW'(src_s3[i]) << (TW - i);
      ge[i]    = (src_rem[i] >= trial[i]);
      // stage 0 compare is the overflow flag
      if (i == 0) begin
        meta_d[i].sat = ge[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NumStg; i++) begin
        rem_q[i]  <= ge[i] ? src_rem[i] - trial[i] : src_rem[i];
        s3_q[i]   <= src_s3[i];
        t_q[i]    <= {src_t[i][TW-2:0], ge[i]};
        meta_q[i] <= meta_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NumStg-2:0], valid_i};
    end
  end

  assign valid_o     = v_q[NumStg-1];
  assign data_o.t    = t_q[NumStg-1];
  assign data_o.meta = meta_q[NumStg-1];

endmodule

### rtl/tarq_sqrt.sv
// ----------------------------------------------------------------------------
// tarq_sqrt: pipelined integer square root
// Digit-by-digit floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tarq_sqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  tarq_pkg::tarq_quot_t data_i,
  output logic                 valid_o,
  output tarq_pkg::tarq_root_t data_o
);
  import tarq_pkg::*;

  localparam int NumStg = FracBits;

  logic [RootRemW-1:0] src_r [NumStg];
  logic [FracBits-1:0] src_q [NumStg];
  logic [TW-1:0]       src_t [NumStg];
  tarq_meta_t          src_m [NumStg];
  logic [RootRemW-1:0] rr    [NumStg];
  logic [RootRemW-1:0] cand  [NumStg];
  logic                ge    [NumStg];
  logic [RootRemW-1:0] r_q   [NumStg];
  logic [FracBits-1:0] q_q   [NumStg];
  logic [TW-1:0]       t_q   [NumStg];
  tarq_meta_t          m_q   [NumStg];
  logic [NumStg-1:0]   v_q;

  always_comb begin
    for (int i = 0; i < NumStg; i++) begin
      if (i == 0) begin
        src_r[i] = '0;
        src_q[i] = '0;
        src_t[i] = data_i.t;
        src_m[i] = data_i.meta;
      end else begin
        src_r[i] = r_q[i-1];
        src_q[i] = q_q[i-1];
        src_t[i] = t_q[i-1];
        src_m[i] = m_q[i-1];
      end
      rr[i]   = {src_r[i][RootRemW-3:0], src_t[i][TW-1 -: 2]};
      cand[i] = RootRemW'({src_q[i], 2'b01});
      ge[i]   = (rr[i] >= cand[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NumStg; i++) begin
        r_q[i] <= ge[i] ? rr[i] - cand[i] : rr[i];
        q_q[i] <= {src_q[i][FracBits-2:0], ge[i]};
        t_q[i] <= src_t[i] << 2;
        m_q[i] <= src_m[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NumStg-2:0], valid_i};
    end
  end

  assign valid_o     = v_q[NumStg-1];
  assign data_o.q    = q_q[NumStg-1];
  assign data_o.meta = m_q[NumStg-1];

endmodule

### sim/tetra_aspect_ratio_quality_tb.sv
// ----------------------------------------------------------------------------
// tetra_aspect_ratio_quality_tb: self-checking bench for the tetrahedron quality block
// Sends directed and random tetrahedra through the valid/ready input channel
// and predicts each quality with exact integer arithmetic. Every result is
// compared, field by field, against the oldest pending prediction. Random
// bursts and gaps are used on the input side and a changing stall pattern on
// the output side.
// ----------------------------------------------------------------------------
module tetra_aspect_ratio_quality_tb;
  import tarq_pkg::*;

  localparam int NumRandom  = 550;
  localparam int DrainWait  = 70;     // longer than the pipeline depth
  localparam int OneQ       = 1 << FracBits;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  tarq_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  tarq_out_t out_data_o;

  tetra_aspect_ratio_quality dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Tetrahedra waiting to be sent; the matching flag asks the driver to hold
  // off until every outstanding result has come back first.
  tarq_in_t  tet_q[$];
  bit        hold_q[$];
  // Predicted results in transaction order
  tarq_out_t quality_exp_q[$];
  int        err_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Quality predictor: S = sum of six squared edges, D = 6 * signed volume.
  // |Q| is the largest Q <= 1.0 with Q^2 * S^3 <= 432 * D^2 * 2^(2*FracBits),
  // signed like D. S == 0 means every vertex coincides.
  // --------------------------------------------------------------------------
  function automatic tarq_out_t predict_quality(tarq_in_t t);
    longint     p[4][3];
    longint     dv[3][3];
    longint     cr[3];
    longint     sum_sq, vol6;
    logic [255:0] s3, rhs, lhs, cand;
    int         q;
    bit         neg;
    tarq_out_t  r;
    p[0][0] = t.a_x; p[0][1] = t.a_y; p[0][2] = t.a_z;
    p[1][0] = t.b_x; p[1][1] = t.b_y; p[1][2] = t.b_z;
    p[2][0] = t.c_x; p[2][1] = t.c_y; p[2][2] = t.c_z;
    p[3][0] = t.d_x; p[3][1] = t.d_y; p[3][2] = t.d_z;
    sum_sq = 0;
    for (int i = 0; i < 4; i++)
      for (int j = i + 1; j < 4; j++)
        for (int k = 0; k < 3; k++)
          sum_sq += (p[j][k] - p[i][k]) * (p[j][k] - p[i][k]);
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        dv[i][k] = p[i+1][k] - p[0][k];
    for (int k = 0; k < 3; k++)
      cr[k] = dv[0][(k+1)%3] * dv[1][(k+2)%3] - dv[0][(k+2)%3] * dv[1][(k+1)%3];
    vol6 = dv[2][0] * cr[0] + dv[2][1] * cr[1] + dv[2][2] * cr[2];
    neg  = vol6 < 0;
    if (neg) vol6 = -vol6;
    r = '0;
    if (sum_sq == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    s3  = 256'(sum_sq);
    s3  = s3 * 256'(sum_sq) * 256'(sum_sq);
    rhs = 256'(vol6) * 256'(vol6) * 256'(K2);
    rhs = rhs << (2 * FracBits);
    q = 0;
    for (int b = FracBits; b >= 0; b--) begin
      cand = 256'(q | (1 << b));
      if (cand > OneQ) continue;
      lhs = cand * cand * s3;
      if (lhs <= rhs) q = int'(cand);
    end
    r.quality = neg ? -QualW'(q) : QualW'(q);
    return r;
  endfunction

  function automatic tarq_in_t make_tet(int v[12]);
    tarq_in_t t;
    t.a_x = CoordW'(v[0]); t.a_y = CoordW'(v[1]);  t.a_z = CoordW'(v[2]);
    t.b_x = CoordW'(v[3]); t.b_y = CoordW'(v[4]);  t.b_z = CoordW'(v[5]);
    t.c_x = CoordW'(v[6]); t.c_y = CoordW'(v[7]);  t.c_z = CoordW'(v[8]);
    t.d_x = CoordW'(v[9]); t.d_y = CoordW'(v[10]); t.d_z = CoordW'(v[11]);
    return t;
  endfunction

  function automatic void queue_tet(tarq_in_t t);
    tet_q = {tet_q, t};
  endfunction

  function automatic int srand_range(int lim);
    return $urandom_range(2 * lim) - lim;
  endfunction

  // Regular tetrahedron around an offset, with optional jitter and inversion
  function automatic tarq_in_t regular_tet(int s, int ox, int oy, int oz, int jit, bit inv);
    int sg[12] = '{1, 1, 1, 1, -1, -1, -1, 1, -1, -1, -1, 1};
    int v[12];
    int off[3];
    off = '{ox, oy, oz};
    for (int i = 0; i < 12; i++)
      v[i] = sg[i] * s + off[i % 3] + (jit > 0 ? srand_range(jit) : 0);
    if (inv)
      for (int k = 0; k < 3; k++) begin
        int tmp;
        tmp = v[3+k]; v[3+k] = v[6+k]; v[6+k] = tmp;
      end
    return make_tet(v);
  endfunction

  function automatic tarq_in_t random_tet();
    int v[12];
    int lim, sc;
    case ($urandom_range(9))
      0, 1, 2: begin      // anything the fields allow
        for (int i = 0; i < 12; i++) v[i] = $urandom_range(65535) - 32768;
      end
      3, 4: begin         // small, close-by vertices
        lim = $urandom_range(1, 40);
        for (int i = 0; i < 12; i++) v[i] = srand_range(lim);
      end
      5, 6: begin         // near-regular shapes, both orientations
        sc = $urandom_range(1, 8000);
        return regular_tet(sc, srand_range(16000), srand_range(16000), srand_range(16000),
                           $urandom_range(0, sc / 4), 1'($urandom_range(1)));
      end
      7: begin            // flat: fourth vertex on the plane (affine combo)
        for (int i = 0; i < 9; i++) v[i] = srand_range(10000);
        for (int k = 0; k < 3; k++) v[9+k] = v[3+k] + v[6+k] - v[k];
      end
      8: begin            // repeated vertex, sometimes all repeated
        for (int i = 0; i < 3; i++) v[i] = $urandom_range(65535) - 32768;
        for (int i = 3; i < 12; i++) v[i] = v[i % 3];
        if ($urandom_range(1)) v[$urandom_range(3, 11)] = $urandom_range(65535) - 32768;
      end
      default: begin      // extremes only
        for (int i = 0; i < 12; i++) v[i] = $urandom_range(1) ? 32767 : -32768;
      end
    endcase
    return make_tet(v);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus build-up and end of run
  // --------------------------------------------------------------------------
  initial begin
    int v[12];
    // all zero and all coincident: degenerate
    v = '{default: 0};                    queue_tet(make_tet(v));
    v = '{default: -32768};               queue_tet(make_tet(v));
    v = '{default: 32767};                queue_tet(make_tet(v));
    // regular, unit and large, both orientations; one far off center
    queue_tet(regular_tet(1, 0, 0, 0, 0, 0));
    queue_tet(regular_tet(1, 0, 0, 0, 0, 1));
    queue_tet(regular_tet(16383, 0, 0, 0, 0, 0));
    queue_tet(regular_tet(16383, -1, -1, -1, 0, 1));
    queue_tet(regular_tet(100, 20000, -20000, 15000, 0, 0));
    // flat with S > 0: collinear, coplanar, three vertices coincident
    v = '{0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 3};             queue_tet(make_tet(v));
    v = '{0, 0, 5, 9, 0, 5, 0, 7, 5, -3, -3, 5};           queue_tet(make_tet(v));
    v = '{10, 10, 10, 10, 10, 10, -4, 8, 2, 10, 10, 10};   queue_tet(make_tet(v));
    // corner-of-box tetrahedra spanning the whole range
    v = '{-32768, -32768, -32768, 32767, -32768, -32768,
          -32768, 32767, -32768, -32768, -32768, 32767};   queue_tet(make_tet(v));
    v = '{-32768, -32768, -32768, -32768, 32767, -32768,
          32767, -32768, -32768, -32768, -32768, 32767};   queue_tet(make_tet(v));
    v = '{32767, 32767, -32768, -32768, 32767, 32767,
          32767, -32768, 32767, -32768, -32768, -32768};   queue_tet(make_tet(v));
    // sliver: tiny volume relative to edges
    v = '{-32768, 0, 0, 32767, 0, 0, 0, 32767, 0, 0, 32766, 1}; queue_tet(make_tet(v));
    for (int i = 0; i < tet_q.size(); i++) hold_q = {hold_q, 1'b0};
    for (int i = 0; i < NumRandom; i++) begin
      queue_tet(random_tet());
      // wait for the pipeline to empty before a few items
      hold_q = {hold_q, (i == 0 || i == NumRandom / 2 || $urandom_range(99) == 0)};
    end

    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (tet_q.size() == 0);
    @(posedge clk_i);
    while (in_valid_i) @(posedge clk_i);
    while (quality_exp_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps. Valid holds
  // with stable data until the transaction is taken.
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o)
        quality_exp_q = {quality_exp_q, predict_quality(in_data_i)};
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (tet_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (hold_q[0] && (quality_exp_q.size() != 0 || (in_valid_i && in_ready_o)
                                   || out_valid_o)) begin
          in_valid_i <= 1'b0;   // pipeline drains before this one goes in
        end else begin
          in_valid_i <= 1'b1;
          in_data_i  <= tet_q.pop_front();
          void'(hold_q.pop_front());
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver stall pattern: at random intervals switch between always
  // ready, coin-flip ready and long stalls with short ready windows.
  // --------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_mode  <= 0;
      mode_left   <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(2);
        mode_left  <= $urandom_range(50, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(1));
        default: out_ready_i <= ($urandom_range(7) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result transaction against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tarq_out_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (quality_exp_q.size() == 0) begin
        $error("unexpected result: quality %0d degenerate %0b",
               out_data_o.quality, out_data_o.degenerate);
        err_cnt = err_cnt + 1;
      end else begin
        exp_r = quality_exp_q.pop_front();
        if (out_data_o.quality !== exp_r.quality) begin
          $error("quality: expected %0d, got %0d", exp_r.quality, out_data_o.quality);
          err_cnt = err_cnt + 1;
        end
        if (out_data_o.degenerate !== exp_r.degenerate) begin
          $error("degenerate: expected %0b, got %0b",
                 exp_r.degenerate, out_data_o.degenerate);
          err_cnt = err_cnt + 1;
        end
      end
    end
  end

endmodule

### filelist.f
rtl/tarq_pkg.sv
rtl/tarq_geom.sv
rtl/tarq_power.sv
rtl/tarq_div.sv
rtl/tarq_sqrt.sv
rtl/tetra_aspect_ratio_quality.sv
sim/tetra_aspect_ratio_quality_tb.sv
